// ===== rtl/ilb_pkg.sv =====
`timescale 1ns / 1ps
package ilb_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  // Fixed field widths of the ports
  localparam int REQ_W  = 4;
  localparam int IDX_W  = 5;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;

  // Length counts 0 .. DEPTH; positions use the same width
  localparam int LEN_W = $clog2(DEPTH + 1);
  // Width in which a request index and the length are compared
  localparam int CMP_W = (LEN_W > IDX_W) ? LEN_W : IDX_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH     = 4'd0,
    REQ_POP      = 4'd1,
    REQ_INSERT   = 4'd2,
    REQ_ERASE    = 4'd3,
    REQ_READ     = 4'd4,
    REQ_FRONT    = 4'd5,
    REQ_BACK     = 4'd6,
    REQ_CLEAR    = 4'd7,
    REQ_TRUNCATE = 4'd8
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ERASE
  } cell_op_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t         op;
    logic [LEN_W-1:0] idx;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] rd_pos;
  } ilb_ctrl_t;

endpackage

// ===== rtl/ilb_cell.sv =====
`timescale 1ns / 1ps
module ilb_cell (
  input  logic                           clk,
  input  logic [ilb_pkg::LEN_W-1:0]      pos,
  input  ilb_pkg::ilb_ctrl_t             ctrl,
  input  logic [ilb_pkg::DATA_WIDTH-1:0] new_data,
  input  logic [ilb_pkg::DATA_WIDTH-1:0] left_data,
  input  logic [ilb_pkg::DATA_WIDTH-1:0] right_data,
  output logic [ilb_pkg::DATA_WIDTH-1:0] data,
  output logic [ilb_pkg::DATA_WIDTH-1:0] rd_data
);
  import ilb_pkg::*;

  logic [DATA_WIDTH-1:0] data_next;

  always_comb begin
    data_next = data;
    case (ctrl.op)
      CELL_INSERT: begin
        // Take the new element at the slot, move later ones up by one
        if (pos == ctrl.idx) begin
          data_next = new_data;
        end else if (pos > ctrl.idx && pos <= ctrl.len) begin
          data_next = left_data;
        end
      end
      CELL_ERASE: begin
        if (pos >= ctrl.idx) begin
          data_next = right_data;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign rd_data = (pos == ctrl.rd_pos) ? data : '0;

endmodule

// ===== rtl/indexed_list_buffer_unit.sv =====
`timescale 1ns / 1ps
// Ordered list store of DEPTH elements held in a chain of cells, one element per
// cell. Every request (push, pop, insert, erase, read, front, back, clear,
// truncate) acts on accept: an insert or erase shifts all later elements by one
// place in the same cycle, each cell taking from its neighbour. A new item is
// accepted every cycle and its result appears in the output register on the next
// cycle; while that result is stalled, input is stalled as well. No clearing
// pass follows reset: cells beyond the length are never read.
module indexed_list_buffer_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ilb_pkg::REQ_W-1:0]   req_type,
  input  logic [ilb_pkg::IDX_W-1:0]   index,
  input  logic [ilb_pkg::VAL_W-1:0]   value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ilb_pkg::VAL_W-1:0]   read_data,
  output logic [ilb_pkg::STAT_W-1:0]  status,
  output logic [ilb_pkg::IDX_W-1:0]   count
);
  import ilb_pkg::*;

  logic [LEN_W-1:0]      length;
  logic [LEN_W-1:0]      length_next;
  logic                  accept;
  logic [CMP_W-1:0]      idx_c;
  logic [CMP_W-1:0]      len_c;
  logic                  full;
  logic                  empty;
  logic                  rd_ok;
  status_t               st;
  ilb_ctrl_t             ctrl;
  logic [DATA_WIDTH-1:0] new_data;
  logic [DATA_WIDTH-1:0] rd_sel;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign idx_c    = CMP_W'(index);
  assign len_c    = CMP_W'(length);
  assign full     = (length == LEN_W'(DEPTH));
  assign empty    = (length == '0);
  assign new_data = DATA_WIDTH'(value);

  always_comb begin
    length_next = length;
    st          = ST_OK;
    rd_ok       = 1'b0;
    ctrl.op     = CELL_HOLD;
    ctrl.idx    = LEN_W'(idx_c);
    ctrl.len    = length;
    ctrl.rd_pos = LEN_W'(idx_c);
    case (req_type)
      REQ_PUSH: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          ctrl.op     = CELL_INSERT;
          ctrl.idx    = length;
          length_next = length + 1'b1;
        end
      end
      REQ_POP: begin
        if (!empty) begin
          length_next = length - 1'b1;
        end
      end
      REQ_INSERT: begin
        // Range check comes before the full check
        if (idx_c > len_c) begin
          st = ST_RANGE;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          ctrl.op     = CELL_INSERT;
          length_next = length + 1'b1;
        end
      end
      REQ_ERASE: begin
        if (idx_c >= len_c) begin
          st = ST_RANGE;
        end else begin
          ctrl.op     = CELL_ERASE;
          length_next = length - 1'b1;
        end
      end
      REQ_READ: begin
        if (idx_c >= len_c) begin
          st = ST_RANGE;
        end else begin
          rd_ok = 1'b1;
        end
      end
      REQ_FRONT: begin
        ctrl.rd_pos = '0;
        if (empty) begin
          st = ST_RANGE;
        end else begin
          rd_ok = 1'b1;
        end
      end
      REQ_BACK: begin
        ctrl.rd_pos = length - 1'b1;
        if (empty) begin
          st = ST_RANGE;
        end else begin
          rd_ok = 1'b1;
        end
      end
      REQ_CLEAR: begin
        length_next = '0;
      end
      REQ_TRUNCATE: begin
        if (idx_c < len_c) begin
          length_next = LEN_W'(idx_c);
        end
      end
      default: begin
        length_next = length;
      end
    endcase
    // Hold the chain unless an item is taken this cycle
    if (!accept) begin
      ctrl.op = CELL_HOLD;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end

    ilb_cell u_cell (
      .clk        (clk),
      .pos        (LEN_W'(i)),
      .ctrl       (ctrl),
      .new_data   (new_data),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .rd_data    (cell_rd[i])
    );
  end

  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_sel = rd_sel | cell_rd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        length    <= length_next;
        out_valid <= 1'b1;
        read_data <= rd_ok ? VAL_W'(rd_sel) : '0;
        status    <= st;
        count     <= IDX_W'(length_next);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
